@@ rtl/cbeg_pkg.sv @@
// shared types and constants of the contact bounce event generator
package cbeg_pkg;

  localparam int TimeW     = 32;
  localparam int StateW    = 4;
  localparam int FracW     = 16;
  localparam int RestW     = 17;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 32;
  localparam int ProdW     = TimeW + RestW;
  localparam int MaxBouncesDef = 16;

  localparam logic [TimeW-1:0]  FirstFlightRst = TimeW'(1000);
  localparam logic [RestW-1:0]  RestitutionRst = RestW'(32768);
  localparam logic [TimeW-1:0]  MinIntervalRst = TimeW'(1);
  localparam logic [FracW-1:0]  DwellRst       = FracW'(32768);
  localparam logic [StateW-1:0] OpenCodeRst    = StateW'(0);

  typedef enum logic [CfgIdxW-1:0] {
    REG_FIRST_FLIGHT   = 3'd0,
    REG_RESTITUTION    = 3'd1,
    REG_MIN_INTERVAL   = 3'd2,
    REG_DWELL_FRACTION = 3'd3,
    REG_OPEN_CODE      = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OPEN0,
    S_MAKE,
    S_MULD,
    S_OPEN,
    S_ADV,
    S_MULR,
    S_UPD
  } state_t;

endpackage

@@ rtl/cbeg_req_if.sv @@
// break request channel
interface cbeg_req_if;
  import cbeg_pkg::*;

  logic              valid;
  logic              ready;
  logic [TimeW-1:0]  break_time;
  logic [StateW-1:0] from_state;
  logic [StateW-1:0] to_state;

  modport source (output valid, break_time, from_state, to_state, input ready);
  modport sink   (input valid, break_time, from_state, to_state, output ready);
endinterface

@@ rtl/cbeg_evt_if.sv @@
// contact event channel
interface cbeg_evt_if;
  import cbeg_pkg::*;

  logic              valid;
  logic              ready;
  logic [TimeW-1:0]  event_time;
  logic [StateW-1:0] event_state;
  logic [StateW-1:0] prior_state;
  logic              last;

  modport source (output valid, event_time, event_state, prior_state, last, input ready);
  modport sink   (input valid, event_time, event_state, prior_state, last, output ready);
endinterface

@@ rtl/cbeg_cfg_if.sv @@
// configuration write channel
interface cbeg_cfg_if;
  import cbeg_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/contact_bounce_event_generator_unit.sv @@
// contact bounce event generator top level
//
// req takes one break request (break time, state before, state after the
// flight). evt returns the run of contact events for it: open at the break,
// the make at the first hit, then an open/make pair per bounce until the
// interval drops below min_interval, reaches zero or MAX_BOUNCES pairs are
// out. last marks the final event. cfg writes the five registers by index.
// One 32x17 multiplier and one saturating 32-bit adder are shared under a
// small sequencer; req is ready only while the sequencer is idle.
// The first event leaves from S_OPEN0; each bounce goes through two
// multiplies and two adds on the shared units. Events leave through one
// output register; while evt is stalled the sequencer waits at its next
// event and resumes when the register frees.
// Reset loads the register defaults and empties the output register.
module contact_bounce_event_generator_unit #(
  parameter int MAX_BOUNCES = cbeg_pkg::MaxBouncesDef
) (
  input  logic           clk,
  input  logic           rst,
  cbeg_req_if.sink       req,
  cbeg_evt_if.source     evt,
  cbeg_cfg_if.sink       cfg
);
  import cbeg_pkg::*;

  localparam int CntW = ($clog2(MAX_BOUNCES + 1) > 0) ? $clog2(MAX_BOUNCES + 1) : 1;

  // configuration registers
  logic [TimeW-1:0]  first_flight;
  logic [RestW-1:0]  restitution;
  logic [TimeW-1:0]  min_interval;
  logic [FracW-1:0]  dwell_fraction;
  logic [StateW-1:0] open_code;

  // run state
  state_t            state, state_next;
  logic [TimeW-1:0]  hit;
  logic [TimeW-1:0]  interval;
  logic [CntW-1:0]   cycles;
  logic [StateW-1:0] from_st;
  logic [StateW-1:0] to_st;
  logic [ProdW-1:0]  prod;

  // output register
  logic              ovalid;
  logic [TimeW-1:0]  otime;
  logic [StateW-1:0] ostate;
  logic [StateW-1:0] oprior;
  logic              olast;

  // shared units and controls
  logic              emit_req;
  logic              emit;
  logic              add_use_prod;
  logic              mul_use_rest;
  logic [TimeW-1:0]  add_b;
  logic [TimeW:0]    add_sum;
  logic [TimeW-1:0]  add_sat;
  logic [RestW-1:0]  mul_b;
  logic [ProdW-1:0]  mul_p;
  logic              more;
  logic [TimeW-1:0]  ev_time;
  logic [StateW-1:0] ev_state;
  logic              ev_last;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign evt.valid       = ovalid;
  assign evt.event_time  = otime;
  assign evt.event_state = ostate;
  assign evt.prior_state = oprior;
  assign evt.last        = olast;

  assign more = (interval >= min_interval) && (interval != '0)
             && (cycles < CntW'(MAX_BOUNCES));

  assign add_b   = add_use_prod ? prod[FracW +: TimeW] : interval;
  assign add_sum = {1'b0, hit} + {1'b0, add_b};
  assign add_sat = add_sum[TimeW] ? '1 : add_sum[TimeW-1:0];

  assign mul_b = mul_use_rest ? restitution : {1'b0, dwell_fraction};
  assign mul_p = {{RestW{1'b0}}, interval} * {{TimeW{1'b0}}, mul_b};

  assign emit = emit_req && (!ovalid || evt.ready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (req.valid) state_next = S_OPEN0;
      S_OPEN0: if (emit) state_next = S_MAKE;
      S_MAKE:  if (emit) state_next = more ? S_MULD : S_IDLE;
      S_MULD:  state_next = S_OPEN;
      S_OPEN:  if (emit) state_next = S_ADV;
      S_ADV:   state_next = S_MULR;
      S_MULR:  state_next = S_UPD;
      S_UPD:   state_next = S_MAKE;
      default: state_next = S_IDLE;
    endcase
  end

  // datapath controls and event fields
  always_comb begin
    emit_req     = 1'b0;
    add_use_prod = 1'b0;
    mul_use_rest = 1'b0;
    ev_time      = hit;
    ev_state     = to_st;
    ev_last      = 1'b0;
    case (state)
      S_OPEN0: begin
        emit_req = 1'b1;
        ev_state = open_code;
      end
      S_MAKE: begin
        emit_req = 1'b1;
        ev_last  = !more;
      end
      S_OPEN: begin
        emit_req     = 1'b1;
        add_use_prod = 1'b1;
        ev_time      = add_sat;
        ev_state     = open_code;
      end
      S_MULR:  mul_use_rest = 1'b1;
      default: emit_req = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      ovalid         <= 1'b0;
      first_flight   <= FirstFlightRst;
      restitution    <= RestitutionRst;
      min_interval   <= MinIntervalRst;
      dwell_fraction <= DwellRst;
      open_code      <= OpenCodeRst;
    end else begin
      state <= state_next;
      if (emit) begin
        ovalid <= 1'b1;
      end else if (evt.ready) begin
        ovalid <= 1'b0;
      end
      if (cfg.valid) begin
        case (cfg.index)
          REG_FIRST_FLIGHT:   first_flight   <= cfg.data[TimeW-1:0];
          REG_RESTITUTION:    restitution    <= cfg.data[RestW-1:0];
          REG_MIN_INTERVAL:   min_interval   <= cfg.data[TimeW-1:0];
          REG_DWELL_FRACTION: dwell_fraction <= cfg.data[FracW-1:0];
          REG_OPEN_CODE:      open_code      <= cfg.data[StateW-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload and run registers
  always_ff @(posedge clk) begin
    if (emit) begin
      otime  <= ev_time;
      ostate <= ev_state;
      oprior <= from_st;
      olast  <= ev_last;
    end
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          hit      <= req.break_time;
          from_st  <= req.from_state;
          to_st    <= req.to_state;
          interval <= first_flight;
          cycles   <= '0;
        end
      end
      S_OPEN0: if (emit) hit <= add_sat;
      S_MULD:  prod <= mul_p;
      S_ADV:   hit <= add_sat;
      S_MULR:  prod <= mul_p;
      S_UPD: begin
        interval <= (prod[ProdW-1:FracW+TimeW] != '0) ? '1 : prod[FracW +: TimeW];
        cycles   <= cycles + CntW'(1);
      end
      default: ;
    endcase
  end

  // a non-final event always has its run still in progress
  a_run_open: assert property (@(posedge clk) disable iff (rst)
    evt.valid && !evt.last |-> state != S_IDLE)
    else $error("non-final event with no run in progress");

  a_cycles_cap: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> cycles <= CntW'(MAX_BOUNCES))
    else $error("bounce count beyond cap");

  a_nonzero_bounce: assert property (@(posedge clk) disable iff (rst)
    state == S_MULD |-> interval != '0 && interval >= min_interval)
    else $error("bounce started on an ended interval");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready && state == S_OPEN0)
    else $error("request transaction did not start a run");

endmodule
